FILE: hw/rtl/ksbd_pkg.sv
// types and constants shared by the keystroke burst detector
package ksbd_pkg;

    // stored count width, enough for any buffer depth up to 63
    localparam int CNT_W = 6;

    // key code of enter
    localparam logic [7:0] ENTER_CODE = 8'h0D;

    // a burst is reported only above this many stored codes
    localparam logic [CNT_W-1:0] MIN_REPORT_COUNT = 6'd2;

    // gap threshold after reset
    localparam logic [15:0] GAP_RESET = 16'd20;

    // command queue depth and pointer width
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // command from the classifier to the output sequencer
    typedef struct packed {
        logic             store;
        logic [7:0]       code;
        logic [CNT_W-1:0] wr_idx;
        logic             pass_on;
        logic             dropped;
        logic             report;
        logic [CNT_W-1:0] rpt_count;
    } t_cmd;

    // one result beat
    typedef struct packed {
        logic       item_kind;
        logic       pass_on;
        logic [7:0] burst_code;
        logic       last_of_run;
        logic       dropped_overflow;
    } t_res;

    // output sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_BURST
    } t_bk_state;

endpackage

FILE: hw/rtl/ksbd_ifs.sv
// valid/ready channel interfaces for key events, results and configuration

interface ksbd_in_if;
    logic        valid;
    logic        ready;
    logic        key_pressed;
    logic [7:0]  key_code;
    logic [31:0] event_time_ms;

    modport source (output valid, key_pressed, key_code, event_time_ms, input ready);
    modport sink   (input valid, key_pressed, key_code, event_time_ms, output ready);
endinterface

interface ksbd_out_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic       pass_on;
    logic [7:0] burst_code;
    logic       last_of_run;
    logic       dropped_overflow;

    modport source (output valid, item_kind, pass_on, burst_code, last_of_run,
                    dropped_overflow, input ready);
    modport sink   (input valid, item_kind, pass_on, burst_code, last_of_run,
                    dropped_overflow, output ready);
endinterface

interface ksbd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] gap_threshold_ms;

    modport source (output valid, gap_threshold_ms, input ready);
    modport sink   (input valid, gap_threshold_ms, output ready);
endinterface

FILE: hw/rtl/ksbd_front.sv
// front end: accepts key events, tracks press timing and classifies each beat
module ksbd_front #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ksbd_in_if.sink         i_key,
    ksbd_cfg_if.sink        i_cfg,
    input  logic            i_q_full,
    output logic            o_q_push,
    output ksbd_pkg::t_cmd  o_q_cmd
);

    logic [31:0]                    r_last;
    logic [31:0]                    n_last;
    logic [ksbd_pkg::CNT_W-1:0]     r_count;
    logic [ksbd_pkg::CNT_W-1:0]     n_count;
    logic [15:0]                    r_thr;
    logic [31:0]                    gap;
    logic                           new_burst;
    logic                           has_room;
    logic                           accept;
    ksbd_pkg::t_cmd                 cmd;

    // handshakes
    assign i_key.ready = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_key.valid && !i_q_full;

    // gap since last press, wrapping
    assign gap       = i_key.event_time_ms - r_last;
    assign new_burst = gap >= {16'd0, r_thr};
    assign has_room  = r_count < ksbd_pkg::CNT_W'(BUFFER_DEPTH);

    // classify the event
    always_comb begin
        cmd.store     = 1'b0;
        cmd.code      = i_key.key_code;
        cmd.wr_idx    = r_count;
        cmd.pass_on   = 1'b1;
        cmd.dropped   = 1'b0;
        cmd.report    = 1'b0;
        cmd.rpt_count = r_count + 1'b1;
        n_count       = r_count;
        n_last        = r_last;
        if (i_key.key_pressed) begin
            n_last = i_key.event_time_ms;
            if (new_burst) begin
                cmd.store  = 1'b1;
                cmd.wr_idx = '0;
                n_count    = ksbd_pkg::CNT_W'(1);
            end else begin
                cmd.pass_on = 1'b0;
                if (has_room) begin
                    cmd.store  = 1'b1;
                    n_count    = r_count + 1'b1;
                    cmd.report = (r_count >= ksbd_pkg::MIN_REPORT_COUNT) &&
                                 (i_key.key_code == ksbd_pkg::ENTER_CODE);
                end else begin
                    cmd.dropped = 1'b1;
                end
            end
        end
    end

    assign o_q_push = accept;
    assign o_q_cmd  = cmd;

    // timing state and threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_count <= '0;
            r_thr   <= ksbd_pkg::GAP_RESET;
        end else begin
            if (accept) begin
                r_last  <= n_last;
                r_count <= n_count;
            end
            if (i_cfg.valid) begin
                r_thr <= i_cfg.gap_threshold_ms;
            end
        end
    end

endmodule

FILE: hw/rtl/ksbd_cmd_fifo.sv
// short command queue between the classifier and the output sequencer
module ksbd_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ksbd_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output ksbd_pkg::t_cmd  o_cmd,
    output logic            o_empty,
    output logic            o_full
);

    ksbd_pkg::t_cmd           r_mem [ksbd_pkg::QDEPTH];
    logic [ksbd_pkg::QAW:0]   r_wp;
    logic [ksbd_pkg::QAW:0]   r_rp;

    // pointer compare with wrap bit
    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[ksbd_pkg::QAW-1:0] == r_rp[ksbd_pkg::QAW-1:0]) &&
                     (r_wp[ksbd_pkg::QAW] != r_rp[ksbd_pkg::QAW]);
    assign o_cmd   = r_mem[r_rp[ksbd_pkg::QAW-1:0]];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp[ksbd_pkg::QAW-1:0]] <= i_cmd;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/ksbd_back.sv
// back end: code buffer and result sequencer with output register
module ksbd_back #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  ksbd_pkg::t_cmd  i_q_cmd,
    output logic            o_q_pop,
    ksbd_out_if.source      o_res
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [7:0]                 r_buf [BUFFER_DEPTH];
    logic [7:0]                 r_rdata;
    ksbd_pkg::t_bk_state        r_state;
    ksbd_pkg::t_bk_state        n_state;
    logic                       r_out_vld;
    logic                       n_out_vld;
    ksbd_pkg::t_res             r_out;
    ksbd_pkg::t_res             n_out;
    logic [ksbd_pkg::CNT_W-1:0] r_rd_idx;
    logic [ksbd_pkg::CNT_W-1:0] n_rd_idx;
    logic [ksbd_pkg::CNT_W-1:0] r_cnt;
    logic [ksbd_pkg::CNT_W-1:0] n_cnt;
    logic                       out_free;
    logic                       wr_en;
    logic                       last_code;

    assign out_free  = !r_out_vld || o_res.ready;
    assign last_code = (r_rd_idx + 1'b1) == r_cnt;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ksbd_pkg::BK_IDLE;
            r_out_vld <= 1'b0;
            r_rd_idx  <= '0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_rd_idx  <= n_rd_idx;
            r_cnt     <= n_cnt;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // next state and beat generation
    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld && !o_res.ready;
        n_out     = r_out;
        n_rd_idx  = r_rd_idx;
        n_cnt     = r_cnt;
        o_q_pop   = 1'b0;
        wr_en     = 1'b0;
        unique case (r_state)
            ksbd_pkg::BK_IDLE: begin
                if (out_free && !i_q_empty) begin
                    o_q_pop                = 1'b1;
                    wr_en                  = i_q_cmd.store;
                    n_out_vld              = 1'b1;
                    n_out.item_kind        = 1'b0;
                    n_out.pass_on          = i_q_cmd.pass_on;
                    n_out.burst_code       = '0;
                    n_out.last_of_run      = !i_q_cmd.report;
                    n_out.dropped_overflow = i_q_cmd.dropped;
                    if (i_q_cmd.report) begin
                        n_state  = ksbd_pkg::BK_BURST;
                        n_rd_idx = '0;
                        n_cnt    = i_q_cmd.rpt_count;
                    end
                end
            end
            ksbd_pkg::BK_BURST: begin
                if (out_free) begin
                    n_out_vld              = 1'b1;
                    n_out.item_kind        = 1'b1;
                    n_out.pass_on          = 1'b0;
                    n_out.burst_code       = r_rdata;
                    n_out.last_of_run      = last_code;
                    n_out.dropped_overflow = 1'b0;
                    n_rd_idx               = r_rd_idx + 1'b1;
                    if (last_code) begin
                        n_state = ksbd_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = ksbd_pkg::BK_IDLE;
            end
        endcase
    end

    // code buffer, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[i_q_cmd.wr_idx[AW-1:0]] <= i_q_cmd.code;
        end
        r_rdata <= r_buf[n_rd_idx[AW-1:0]];
    end

    // result channel
    assign o_res.valid            = r_out_vld;
    assign o_res.item_kind        = r_out.item_kind;
    assign o_res.pass_on          = r_out.pass_on;
    assign o_res.burst_code       = r_out.burst_code;
    assign o_res.last_of_run      = r_out.last_of_run;
    assign o_res.dropped_overflow = r_out.dropped_overflow;

endmodule

FILE: hw/rtl/keystroke_burst_scanner_detect_unit.sv
// top level of the keystroke burst scanner detector
// a decision beat is written to the command queue on accept, then to the output register
// throughput: one event per cycle while the command queue is not full; a reporting enter press
//   adds one burst beat per stored code (up to BUFFER_DEPTH), one per cycle unless stalled
// the four-entry command queue sets how far the front end may run ahead of the back end
// reset: synchronous active low; clears press time, count, queue, output valid and sets
//   the gap threshold to 20 ms; the code buffer is not cleared
module keystroke_burst_scanner_detect_unit #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ksbd_in_if.sink     i_key,
    ksbd_cfg_if.sink    i_cfg,
    ksbd_out_if.source  o_res
);

    logic           q_push;
    logic           q_pop;
    logic           q_empty;
    logic           q_full;
    ksbd_pkg::t_cmd q_in;
    ksbd_pkg::t_cmd q_out;

    // classifier
    ksbd_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (i_key),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_in)
    );

    // command queue
    ksbd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // buffer and result sequencer
    ksbd_back #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_out),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

    // burst beats carry no decision flags
    a_burst_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.item_kind |-> !o_res.pass_on && !o_res.dropped_overflow)
        else $error("burst beat carries decision flags");

    // a forwarded key ends its run at once
    a_pass_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.item_kind && o_res.pass_on |-> o_res.last_of_run)
        else $error("forwarded key followed by burst beats");

    // a dropped press is swallowed and never starts a report
    a_drop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.dropped_overflow |->
            !o_res.item_kind && !o_res.pass_on && o_res.last_of_run)
        else $error("dropped press forwarded or reported");

    // the queue is never popped while empty
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command queue popped while empty");

endmodule
